/* rtl/core/pst_pkg.sv */
// ============================================================================
// pst_pkg
// Shared types and constants for the periodic slot timer: item layouts,
// command codes and the control word that walks the slot cell chain.
// ============================================================================
package pst_pkg;

    // Command codes of the input item (code 3 is a no-op)
    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_REGISTER   = 2'd1,
        CMD_UNREGISTER = 2'd2
    } t_cmd;

    localparam int unsigned SUBSEC_W = 10;
    localparam logic [SUBSEC_W-1:0] MS_PER_SECOND = 10'd1000;
    localparam logic [SUBSEC_W-1:0] LAST_MS_IN_SECOND = 10'd999;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] interval;
        logic [3:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [15:0]         fired_mask;
        logic [3:0]          granted_slot;
        logic                grant_ok;
        logic [31:0]         uptime_ms;
        logic [31:0]         uptime_seconds;
        logic [SUBSEC_W-1:0] ms_in_second;
    } t_out_item;

    // Control word handed from cell to cell
    typedef struct packed {
        logic       vld;
        logic [1:0] command;
        logic [3:0] slot;
        logic       claimed;
    } t_tok_ctl;

endpackage

/* rtl/core/pst_cell.sv */
// ============================================================================
// pst_cell
// One slot of the timer table: holds period, last fire time and active flag,
// acts on the passing command word and hands it to the next cell.
// ============================================================================
module pst_cell #(
    parameter int CELL_IDX    = 0,
    parameter int SLOT_COUNT  = 16,
    parameter int COUNT_WIDTH = 32,
    parameter int IDX_W       = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pst_pkg::t_tok_ctl     i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_time,
    input  logic [31:0]           i_interval,
    input  logic [SLOT_COUNT-1:0] i_mask,
    input  logic [IDX_W-1:0]      i_grant,
    output pst_pkg::t_tok_ctl     o_ctl,
    output logic [COUNT_WIDTH-1:0] o_time,
    output logic [31:0]           o_interval,
    output logic [SLOT_COUNT-1:0] o_mask,
    output logic [IDX_W-1:0]      o_grant
);

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic                   r_active;
    logic [31:0]            r_period;
    logic [COUNT_WIDTH-1:0] r_last;

    pst_pkg::t_tok_ctl      r_ctl;
    logic [COUNT_WIDTH-1:0] r_time;
    logic [31:0]            r_interval;
    logic [SLOT_COUNT-1:0]  r_mask;
    logic [IDX_W-1:0]       r_grant;

    logic [COUNT_WIDTH-1:0] elapsed;
    logic                   fire;
    logic                   claim;
    logic                   release_slot;
    logic [SLOT_COUNT-1:0]  n_mask;

    always_comb begin
        elapsed = i_time - r_last;
        fire = i_ctl.vld && (i_ctl.command == pst_pkg::CMD_TICK) && r_active &&
               (CMP_W'(elapsed) >= CMP_W'(r_period));
        claim = i_ctl.vld && (i_ctl.command == pst_pkg::CMD_REGISTER) &&
                !i_ctl.claimed && !r_active;
        release_slot = i_ctl.vld && (i_ctl.command == pst_pkg::CMD_UNREGISTER) &&
                       ({28'd0, i_ctl.slot} == 32'(CELL_IDX));
        n_mask = i_mask;
        n_mask[CELL_IDX] = i_mask[CELL_IDX] | fire;
    end

    // Slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (claim) begin
            r_active <= 1'b1;
        end else if (release_slot) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_period <= i_interval;
        end
        if (claim || fire) begin
            r_last <= i_time;
        end
    end

    // Hand the command word on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else begin
            r_ctl.vld <= i_ctl.vld;
        end
        r_ctl.command <= i_ctl.command;
        r_ctl.slot    <= i_ctl.slot;
        r_ctl.claimed <= i_ctl.claimed | claim;
        r_time        <= i_time;
        r_interval    <= i_interval;
        r_mask        <= n_mask;
        r_grant       <= claim ? IDX_W'(CELL_IDX) : i_grant;
    end

    assign o_ctl      = r_ctl;
    assign o_time     = r_time;
    assign o_interval = r_interval;
    assign o_mask     = r_mask;
    assign o_grant    = r_grant;

endmodule

/* rtl/core/periodic_slot_timer.sv */
// ============================================================================
// periodic_slot_timer
// Millisecond uptime counter with a table of periodic slots: tick, register
// and unregister commands, one result item per command item.
// ============================================================================
//
//  channel  | valid / ready             | payload
//  ---------+---------------------------+------------------------------
//  input    | i_in_valid / o_in_ready   | i_in_item  (pst_pkg::t_in_item)
//  output   | o_out_valid / i_out_ready | o_out_item (pst_pkg::t_out_item)
//
//  The accepting edge loads the launch register, the command word then walks
//  one slot cell per cycle, and the output register takes the result from
//  the last cell. One item is in the chain at a time, so the next item is
//  taken only after the word has left the last cell.
//  Reset clears the counters and all active flags at once; no clearing pass.
//  A stalled result waits in the output register, a second one in a skid
//  register; the input is not taken again until the skid register is empty.
//
module periodic_slot_timer #(
    parameter int SLOT_COUNT  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pst_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pst_pkg::t_out_item o_out_item
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Uptime counters
    logic [COUNT_WIDTH-1:0]       r_ms, n_ms;
    logic [pst_pkg::SUBSEC_W-1:0] r_sub, n_sub;
    logic [COUNT_WIDTH-1:0]       r_sec, n_sec;

    // Launch register feeding the first cell
    pst_pkg::t_tok_ctl      r_launch_ctl;
    logic [COUNT_WIDTH-1:0] r_launch_time;
    logic [31:0]            r_launch_interval;

    // Chain links: entry 0 is the launch register, entry k is cell k-1 output
    pst_pkg::t_tok_ctl      link_ctl      [SLOT_COUNT+1];
    logic [COUNT_WIDTH-1:0] link_time     [SLOT_COUNT+1];
    logic [31:0]            link_interval [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0]  link_mask     [SLOT_COUNT+1];
    logic [IDX_W-1:0]       link_grant    [SLOT_COUNT+1];

    logic               r_busy;
    logic               r_out_v;
    pst_pkg::t_out_item r_out;
    logic               r_skid_v;
    pst_pkg::t_out_item r_skid;

    logic               in_acc;
    logic               done;
    pst_pkg::t_out_item res;

    logic [SLOT_COUNT+15:0]  mask_x;
    logic [IDX_W+3:0]        grant_x;
    logic [COUNT_WIDTH+31:0] ms_x;
    logic [COUNT_WIDTH+31:0] sec_x;

    // Accept only with the chain empty and the skid register free
    assign o_in_ready = !r_busy && !r_skid_v;
    assign in_acc     = i_in_valid && o_in_ready;
    assign done       = link_ctl[SLOT_COUNT].vld;

    // Advance the counters on an accepted tick
    always_comb begin
        n_ms  = r_ms;
        n_sub = r_sub;
        n_sec = r_sec;
        if (in_acc && (i_in_item.command == pst_pkg::CMD_TICK)) begin
            n_ms = r_ms + COUNT_WIDTH'(1);
            if (r_sub == pst_pkg::LAST_MS_IN_SECOND) begin
                n_sub = '0;
                n_sec = r_sec + COUNT_WIDTH'(1);
            end else begin
                n_sub = r_sub + pst_pkg::SUBSEC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms  <= '0;
            r_sub <= '0;
            r_sec <= '0;
        end else begin
            r_ms  <= n_ms;
            r_sub <= n_sub;
            r_sec <= n_sec;
        end
    end

    // Launch the command word with the updated time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_ctl.vld <= 1'b0;
        end else begin
            r_launch_ctl.vld <= in_acc;
        end
        if (in_acc) begin
            r_launch_ctl.command <= i_in_item.command;
            r_launch_ctl.slot    <= i_in_item.slot;
            r_launch_ctl.claimed <= 1'b0;
            r_launch_time        <= n_ms;
            r_launch_interval    <= i_in_item.interval;
        end
    end

    assign link_ctl[0]      = r_launch_ctl;
    assign link_time[0]     = r_launch_time;
    assign link_interval[0] = r_launch_interval;
    assign link_mask[0]     = '0;
    assign link_grant[0]    = '0;

    // Row of slot cells, one per table entry
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        pst_cell #(
            .CELL_IDX   (g),
            .SLOT_COUNT (SLOT_COUNT),
            .COUNT_WIDTH(COUNT_WIDTH),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (link_ctl[g]),
            .i_time     (link_time[g]),
            .i_interval (link_interval[g]),
            .i_mask     (link_mask[g]),
            .i_grant    (link_grant[g]),
            .o_ctl      (link_ctl[g+1]),
            .o_time     (link_time[g+1]),
            .o_interval (link_interval[g+1]),
            .o_mask     (link_mask[g+1]),
            .o_grant    (link_grant[g+1])
        );
    end

    // Hold busy from acceptance until the word leaves the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    // Assemble the result; fit parameter widths to the fixed item widths
    always_comb begin
        mask_x  = {16'd0, link_mask[SLOT_COUNT]};
        grant_x = {4'd0, link_grant[SLOT_COUNT]};
        ms_x    = {32'd0, r_ms};
        sec_x   = {32'd0, r_sec};
        res.fired_mask     = mask_x[15:0];
        res.granted_slot   = grant_x[3:0];
        res.grant_ok       = link_ctl[SLOT_COUNT].claimed;
        res.uptime_ms      = ms_x[31:0];
        res.uptime_seconds = sec_x[31:0];
        res.ms_in_second   = r_sub;
    end

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= done;
            end
        end else if (done) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (done) begin
                r_out <= res;
            end
        end else if (done) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

/* rtl/core/pst_checker.sv */
// ============================================================================
// pst_checker
// Port-level checks on the periodic slot timer, bound to the top level.
// ============================================================================
module pst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input pst_pkg::t_in_item  i_in_item,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pst_pkg::t_out_item i_out_item
);

    // A held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // One item at a time: no acceptance right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // A grant and a fire never come from the same command
    a_grant_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.grant_ok |-> i_out_item.fired_mask == 16'd0)
        else $error("grant with fired slots");

    // A failed or absent grant reports slot zero
    a_no_grant_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.grant_ok |-> i_out_item.granted_slot == 4'd0)
        else $error("slot index without a grant");

    // Sub-second count stays below one second
    a_subsec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_item.ms_in_second < pst_pkg::MS_PER_SECOND)
        else $error("sub-second count out of range");

endmodule

bind periodic_slot_timer pst_checker u_pst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_ready (o_in_ready),
    .i_in_item  (i_in_item),
    .i_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .i_out_item (o_out_item)
);

/* dv/periodic_slot_timer_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// periodic_slot_timer_tb
// Self-checking bench for the periodic slot timer. Command items (tick,
// register, unregister, no-op) are queued by a stimulus block and handed to
// a valid/ready driver. Each accepted item runs through a local timer model,
// and the monitor compares every result item field by field with the
// oldest outstanding prediction. Both channels idle at random.
// ============================================================================
module periodic_slot_timer_tb;

    localparam int          SLOTS        = 16;
    // Code 3 has no member in the command enum; the block treats it as a no-op.
    localparam logic [1:0]  CMD_NOP      = 2'd3;
    localparam int          RANDOM_ITEMS = 675;
    localparam int          IDLE_PCT     = 19;
    // Window of accepted items during which neither side idles.
    localparam int          CALM_FIRST   = 400;
    localparam int          CALM_LAST    = 650;
    // Cycles without any handshake before the run is declared hung.
    localparam int          HANG_LIMIT   = 2000;
    // Cycles to watch for stray results once nothing is outstanding.
    localparam int          DRAIN_CYCLES = 4 * (SLOTS + 2);

    logic                i_clk   = 1'b0;
    logic                rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_ready = 1'b0;
    pst_pkg::t_in_item   in_item   = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    pst_pkg::t_out_item  o_out_item;

    pst_pkg::t_in_item   pending_cmds[$];
    pst_pkg::t_out_item  awaited_reports[$];

    int         cmds_taken   = 0;
    int         err_count    = 0;
    int         stall_cycles = 0;
    logic       calm;

    // Timer model state: counters, slot table and active flags.
    logic [31:0]       ms_now   = '0;
    logic [9:0]        subsec   = '0;
    logic [31:0]       secs     = '0;
    logic [31:0]       period    [SLOTS];
    logic [31:0]       last_fire [SLOTS];
    logic [SLOTS-1:0]  active   = '0;

    periodic_slot_timer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign calm = (cmds_taken >= CALM_FIRST) && (cmds_taken < CALM_LAST);

    // Apply one command to the timer model and return the report it yields.
    task automatic apply_command(input pst_pkg::t_in_item cmd,
                                 output pst_pkg::t_out_item rpt);
        logic [31:0] elapsed;
        logic        found;
        rpt   = '0;
        found = 1'b0;
        case (cmd.command)
            pst_pkg::CMD_TICK: begin
                ms_now = ms_now + 32'd1;
                if (subsec == pst_pkg::LAST_MS_IN_SECOND) begin
                    subsec = '0;
                    secs   = secs + 32'd1;
                end else begin
                    subsec = subsec + 10'd1;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (active[i]) begin
                        elapsed = ms_now - last_fire[i];
                        if (elapsed >= period[i]) begin
                            last_fire[i]      = ms_now;
                            rpt.fired_mask[i] = 1'b1;
                        end
                    end
                end
            end
            pst_pkg::CMD_REGISTER: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !active[i]) begin
                        found            = 1'b1;
                        period[i]        = cmd.interval;
                        last_fire[i]     = ms_now;
                        active[i]        = 1'b1;
                        rpt.granted_slot = i[3:0];
                        rpt.grant_ok     = 1'b1;
                    end
                end
            end
            pst_pkg::CMD_UNREGISTER: begin
                active[cmd.slot] = 1'b0;
            end
            default: ;
        endcase
        rpt.uptime_ms      = ms_now;
        rpt.uptime_seconds = secs;
        rpt.ms_in_second   = subsec;
    endtask

    function automatic pst_pkg::t_in_item make_cmd(logic [1:0] code, logic [31:0] ivl,
                                                   logic [3:0] slt);
        pst_pkg::t_in_item c;
        c.command  = code;
        c.interval = ivl;
        c.slot     = slt;
        return c;
    endfunction

    // Pick an interval: mostly short periods so slots fire often, some long
    // ones, a few full-range values and the extremes.
    function automatic logic [31:0] pick_interval();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom_range(40);
        else if (roll < 85)
            return $urandom_range(2000);
        else if (roll < 95)
            return $urandom;
        else if (roll < 97)
            return 32'd0;
        else if (roll < 98)
            return 32'd1;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // Driver: predict each accepted item, then launch the next one unless
    // this cycle is an idle one. Valid gets exactly one assignment per edge.
    always @(posedge i_clk) begin
        pst_pkg::t_out_item rpt;
        logic               next_valid;
        next_valid = in_valid;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                apply_command(in_item, rpt);
                awaited_reports.push_back(rpt);
                cmds_taken <= cmds_taken + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_cmds.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_item <= pending_cmds.pop_front();
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // Receiver side: drop ready at random, never inside the calm window.
    always @(posedge i_clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        pst_pkg::t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("result item with no prediction outstanding: %h", o_out_item);
                err_count <= err_count + 1;
            end else begin
                want = awaited_reports.pop_front();
                if (o_out_item.fired_mask !== want.fired_mask) begin
                    $error("fired_mask: expected %h, actual %h",
                           want.fired_mask, o_out_item.fired_mask);
                    err_count <= err_count + 1;
                end
                if (o_out_item.granted_slot !== want.granted_slot) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           want.granted_slot, o_out_item.granted_slot);
                    err_count <= err_count + 1;
                end
                if (o_out_item.grant_ok !== want.grant_ok) begin
                    $error("grant_ok: expected %b, actual %b",
                           want.grant_ok, o_out_item.grant_ok);
                    err_count <= err_count + 1;
                end
                if (o_out_item.uptime_ms !== want.uptime_ms) begin
                    $error("uptime_ms: expected %0d, actual %0d",
                           want.uptime_ms, o_out_item.uptime_ms);
                    err_count <= err_count + 1;
                end
                if (o_out_item.uptime_seconds !== want.uptime_seconds) begin
                    $error("uptime_seconds: expected %0d, actual %0d",
                           want.uptime_seconds, o_out_item.uptime_seconds);
                    err_count <= err_count + 1;
                end
                if (o_out_item.ms_in_second !== want.ms_in_second) begin
                    $error("ms_in_second: expected %0d, actual %0d",
                           want.ms_in_second, o_out_item.ms_in_second);
                    err_count <= err_count + 1;
                end
            end
        end
    end

    // Count cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < HANG_LIMIT)
            @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int roll;
        int reg_pct;
        logic [1:0] code;

        // Directed part: empty-table tick, no-op, fill the table with the
        // interval extremes, overflow it, then free slots and reclaim one.
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_TICK, 32'hFFFF_FFFF, 4'hF));
        pending_cmds.push_back(make_cmd(CMD_NOP, 32'h5555_AAAA, 4'hA));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'd0, 4'h0));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'd1, 4'hF));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 4'h0));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'h8000_0000, 4'h5));
        for (int i = 4; i < SLOTS; i++)
            pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, i * 3, 4'(i)));
        // Table full: grant must fail
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'd7, 4'h3));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_TICK, 32'h0, 4'h0));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_UNREGISTER, 32'hAAAA_5555, 4'h0));
        // Freeing a slot that is already free
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_UNREGISTER, 32'h0, 4'h0));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_UNREGISTER, 32'h0, 4'hF));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_REGISTER, 32'd2, 4'h0));
        pending_cmds.push_back(make_cmd(pst_pkg::CMD_TICK, 32'h0, 4'h0));

        // Random part: mostly ticks so the uptime advances; the
        // register share shifts between segments so the table runs near
        // empty, half full and full. Unused fields carry random noise.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case ((k / 150) % 3)
                0:       reg_pct = 4;
                1:       reg_pct = 10;
                default: reg_pct = 16;
            endcase
            roll = $urandom_range(99);
            if (roll < reg_pct)
                code = pst_pkg::CMD_REGISTER;
            else if (roll < reg_pct + 7)
                code = pst_pkg::CMD_UNREGISTER;
            else if (roll < reg_pct + 8)
                code = CMD_NOP;
            else
                code = pst_pkg::CMD_TICK;
            pending_cmds.push_back(make_cmd(code,
                (code == pst_pkg::CMD_REGISTER) ? pick_interval() : $urandom,
                4'($urandom_range(15))));
        end

        // Hold reset, then release it once.
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Wait until every item is in and every prediction has been met.
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || in_valid || awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && awaited_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
